/* rtl/bfba_pkg.sv */
// Package with the word types, status codes and controller states of the best-fit allocator.
package bfba_pkg;

	localparam int unsigned IdWidth   = 8;
	localparam int unsigned SizeWidth = 24;

	localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
	localparam logic [1:0] STATUS_NO_FIT    = 2'd1;
	localparam logic [1:0] STATUS_APPENDED  = 2'd2;
	localparam logic [1:0] STATUS_FULL      = 2'd3;

	localparam logic OP_APPEND   = 1'b0;
	localparam logic OP_ALLOCATE = 1'b1;

	typedef struct packed {
		logic                 operation;
		logic [IdWidth-1:0]   block_number;
		logic [SizeWidth-1:0] amount;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [IdWidth-1:0]   chosen_block;
		logic [SizeWidth-1:0] chosen_size;
	} rsp_t;

	typedef struct packed {
		logic [IdWidth-1:0]   id;
		logic [SizeWidth-1:0] size;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_WBACK = 3'b100
	} state_t;

endpackage

/* rtl/bfba_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module bfba_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/best_fit_block_allocator.sv */
// Top level of the best-fit block allocator: block table in RAM and a scanning controller.
// An append word's result is registered and valid in the cycle after acceptance.
// An allocate word scans the whole table:
// one RAM read per stored block, a compare drain, then a write back.
// A new word is taken only once the previous allocate has finished its write back.
// Reset clears the block count and the controller; RAM contents need no clearing.
module best_fit_block_allocator #(
	parameter int unsigned MAX_BLOCKS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  bfba_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output bfba_pkg::rsp_t  rsp
);

	import bfba_pkg::*;

	localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        rd_idx_q;
	logic                 cmp_vld_s1;
	logic [AW-1:0]        cmp_idx_s1;
	logic [SizeWidth-1:0] amount_q;
	logic                 found_q;
	logic [AW-1:0]        best_idx_q;
	entry_t               best_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic                 out_free;
	logic                 accept;
	logic                 table_full;
	logic                 issue;
	logic                 better;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	entry_t               ram_wdata;
	entry_t               ram_rdata;
	logic                 rsp_load;
	rsp_t                 rsp_next;

	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign req_stall  = !((state_q == ST_IDLE) && out_free);
	assign accept     = req_valid && !req_stall;
	assign table_full = (count_q == CW'(MAX_BLOCKS));
	assign issue      = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	assign better     = (ram_rdata.size >= amount_q) && (!found_q || (ram_rdata.size < best_q.size));

	bfba_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = '{id: req.block_number, size: req.amount};
		rsp_load  = 1'b0;
		rsp_next  = '{status: STATUS_APPENDED, chosen_block: '0, chosen_size: '0};
		case (state_q)
			ST_IDLE: begin
				if (accept && (req.operation == OP_APPEND)) begin
					rsp_load = 1'b1;
					if (table_full) begin
						rsp_next.status = STATUS_FULL;
					end else begin
						ram_we = 1'b1;
					end
				end
			end
			ST_WBACK: begin
				if (out_free) begin
					rsp_load = 1'b1;
					if (found_q) begin
						ram_we    = 1'b1;
						ram_waddr = best_idx_q;
						ram_wdata = '{id: best_q.id, size: '0};
						rsp_next  = '{status: STATUS_ALLOCATED, chosen_block: best_q.id,
							chosen_size: best_q.size};
					end else begin
						rsp_next.status = STATUS_NO_FIT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.operation == OP_ALLOCATE) begin
							state_q  <= ST_SCAN;
							rd_idx_q <= '0;
							found_q  <= 1'b0;
						end else if (!table_full) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (cmp_vld_s1 && better) begin
						found_q <= 1'b1;
					end
					if (!issue && !cmp_vld_s1) begin
						state_q <= ST_WBACK;
					end
				end
				ST_WBACK: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_idx_q[AW-1:0];
		if (accept) begin
			amount_q <= req.amount;
		end
		if ((state_q == ST_SCAN) && cmp_vld_s1 && better) begin
			best_idx_q <= cmp_idx_s1;
			best_q     <= ram_rdata;
		end
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* verif/bfba_monitor.sv */
// Monitor for the best-fit block allocator: predicts every result word and compares it.
module bfba_monitor #(
	parameter int unsigned MAX_BLOCKS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  bfba_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  bfba_pkg::rsp_t rsp,
	output int unsigned    mismatches,
	output int unsigned    outstanding,
	output int unsigned    allocated_seen,
	output int unsigned    no_fit_seen,
	output int unsigned    appended_seen,
	output int unsigned    full_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import bfba_pkg::*;

	entry_t      shadow_blocks [MAX_BLOCKS];
	int unsigned block_total;
	rsp_t        answers_due [$];
	rsp_t        want;

	initial begin
		mismatches = 0;
		outstanding = 0;
		allocated_seen = 0;
		no_fit_seen = 0;
		appended_seen = 0;
		full_seen = 0;
		block_total = 0;
	end

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch, %s", $time, what);
		mismatches++;
	endtask

	function automatic rsp_t best_fit_answer(input req_t w);
		rsp_t        a;
		int          best;
		int unsigned i;
		a = '0;
		if (w.operation == OP_APPEND) begin
			if (block_total >= MAX_BLOCKS) begin
				a.status = STATUS_FULL;
			end else begin
				shadow_blocks[block_total].id = w.block_number;
				shadow_blocks[block_total].size = w.amount;
				block_total++;
				a.status = STATUS_APPENDED;
			end
		end else begin
			best = -1;
			for (i = 0; i < block_total; i++) begin
				if (shadow_blocks[i].size >= w.amount
						&& (best < 0 || shadow_blocks[i].size < shadow_blocks[best].size)) begin
					best = int'(i);
				end
			end
			if (best < 0) begin
				a.status = STATUS_NO_FIT;
			end else begin
				a.status = STATUS_ALLOCATED;
				a.chosen_block = shadow_blocks[best].id;
				a.chosen_size = shadow_blocks[best].size;
				shadow_blocks[best].size = '0;
			end
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_total = 0;
			answers_due.delete();
			outstanding <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				answers_due.push_back(best_fit_answer(req));
			end
			if (rsp_valid && !rsp_stall) begin
				if (answers_due.size() == 0) begin
					report_mismatch($sformatf("result word %h with nothing pending", rsp));
				end else begin
					want = answers_due.pop_front();
					if (rsp.status !== want.status) begin
						report_mismatch($sformatf("status got %0d, expected %0d",
							rsp.status, want.status));
					end
					if (rsp.chosen_block !== want.chosen_block) begin
						report_mismatch($sformatf("chosen_block got %h, expected %h",
							rsp.chosen_block, want.chosen_block));
					end
					if (rsp.chosen_size !== want.chosen_size) begin
						report_mismatch($sformatf("chosen_size got %h, expected %h",
							rsp.chosen_size, want.chosen_size));
					end
					case (want.status)
						STATUS_ALLOCATED: allocated_seen++;
						STATUS_NO_FIT:    no_fit_seen++;
						STATUS_APPENDED:  appended_seen++;
						default:          full_seen++;
					endcase
				end
			end
			outstanding <= answers_due.size();
		end
	end

endmodule

/* verif/tb_best_fit_block_allocator.sv */
// Testbench top for the best-fit block allocator: clock, reset, stimulus and verdict.
module tb_best_fit_block_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import bfba_pkg::*;

	localparam int unsigned BLOCKS         = 64;
	localparam int unsigned RANDOM_WORDS   = 600;
	localparam int unsigned HOLD_OFF       = 400;
	localparam int unsigned DRAIN_CYCLES   = 200;
	localparam int unsigned WATCHDOG_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic steady = 1'b0;
	logic hold_off_go = 1'b0;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned allocated_seen;
	int unsigned no_fit_seen;
	int unsigned appended_seen;
	int unsigned full_seen;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	best_fit_block_allocator #(
		.MAX_BLOCKS(BLOCKS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	bfba_monitor #(
		.MAX_BLOCKS(BLOCKS)
	) monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.allocated_seen(allocated_seen),
		.no_fit_seen   (no_fit_seen),
		.appended_seen (appended_seen),
		.full_seen     (full_seen)
	);

	function automatic req_t make_word(input logic op, input logic [7:0] id,
			input logic [23:0] amount);
		req_t w;
		w.operation = op;
		w.block_number = id;
		w.amount = amount;
		return w;
	endfunction

	function automatic req_t random_word(input int unsigned append_pct);
		req_t w;
		w.operation = ($urandom_range(99) < append_pct) ? OP_APPEND : OP_ALLOCATE;
		w.block_number = 8'($urandom_range(255));
		case ($urandom_range(9))
			0:       w.amount = '0;
			1:       w.amount = '1;
			2, 3, 4: w.amount = 24'($urandom_range(31));
			5, 6:    w.amount = 24'($urandom_range(4095, 32));
			default: w.amount = 24'($urandom());
		endcase
		return w;
	endfunction

	task automatic send_word(input req_t w);
		int unsigned gap;
		gap = 0;
		while (!steady && $urandom_range(99) < 13) gap++;
		if (!steady && $urandom_range(99) < 3) gap += $urandom_range(70, 5);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	initial begin : receiver
		logic held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_go && !held) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_OFF) @(posedge clk);
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= !steady && ($urandom_range(99) < 13);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Timeout after %0d cycles with no word accepted.", quiet);
		$display("FAIL best_fit_block_allocator");
		$finish;
	end

	initial begin : stimulus
		int unsigned i;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(make_word(OP_ALLOCATE, 8'h00, 24'h000000));
		send_word(make_word(OP_ALLOCATE, 8'hFF, 24'hFFFFFF));
		send_word(make_word(OP_APPEND, 8'h00, 24'h000000));
		send_word(make_word(OP_APPEND, 8'hFF, 24'hFFFFFF));
		send_word(make_word(OP_APPEND, 8'h5A, 24'd100));
		send_word(make_word(OP_APPEND, 8'hA5, 24'd100));
		send_word(make_word(OP_APPEND, 8'h5A, 24'd50));
		send_word(make_word(OP_ALLOCATE, 8'h00, 24'h000000));
		send_word(make_word(OP_ALLOCATE, 8'h00, 24'd60));
		send_word(make_word(OP_ALLOCATE, 8'h00, 24'd60));
		send_word(make_word(OP_ALLOCATE, 8'h00, 24'hFFFFFF));
		send_word(make_word(OP_ALLOCATE, 8'h00, 24'hFFFFFF));
		send_word(make_word(OP_ALLOCATE, 8'h00, 24'd51));
		send_word(make_word(OP_ALLOCATE, 8'h00, 24'd50));
		send_word(make_word(OP_ALLOCATE, 8'h00, 24'd1));
		send_word(make_word(OP_ALLOCATE, 8'hFF, 24'h000000));
		send_word(make_word(OP_APPEND, 8'hC3, 24'h800001));
		send_word(make_word(OP_APPEND, 8'h3C, 24'h7FFFFE));
		send_word(make_word(OP_ALLOCATE, 8'h81, 24'h7FFFFE));

		for (i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 150) hold_off_go <= 1'b1;
			if (i == 250) steady <= 1'b1;
			if (i == 380) steady <= 1'b0;
			if (i == 420) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
			end
			send_word(random_word((i >= 520) ? 60 : 16));
		end
		req_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d words: %0d allocated, %0d with no fit, %0d appended, %0d full.",
			allocated_seen + no_fit_seen + appended_seen + full_seen,
			allocated_seen, no_fit_seen, appended_seen, full_seen);
		$display("It included a %0d-cycle result hold-off and a mid-run drain of the block.",
			HOLD_OFF);
		if (mismatches == 0) begin
			$display("PASS best_fit_block_allocator");
		end else begin
			$display("FAIL best_fit_block_allocator");
		end
		$finish;
	end

endmodule
